@@ design/mpr_pkg.sv @@
package mpr_pkg;

	// Arithmetic width of y, the minimum y and the decision value.
	localparam int VALUE_W = 32;
	// Width of x, the vertex and the multiplier's second operand.
	localparam int X_W = 12;

	localparam int COEF_A_W = 8;
	localparam int COEF_B_W = 11;
	localparam int COEF_C_W = 17;
	localparam int EXTENT_W = 10;

	localparam int PX_W = 11;
	localparam int MX_W = 13;

	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;

	// Held coefficients after the curve is turned to open upward.
	localparam int A_W = COEF_A_W + 1;
	localparam int B_W = COEF_B_W + 1;
	localparam int C_W = COEF_C_W + 1;
	localparam int K_W = B_W + 2;

	// Vertex divider: |b| over 2a, one quotient bit per cycle.
	localparam int QUO_W = COEF_B_W;
	localparam int REM_W = COEF_A_W;
	localparam int DIV_CNT_W = $clog2(QUO_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

	localparam int STEP_BIAS = 4;

	localparam logic signed [COEF_A_W-1:0] RST_COEF_A = -8'sd1;
	localparam logic signed [COEF_B_W-1:0] RST_COEF_B = 11'sd2;
	localparam logic signed [COEF_C_W-1:0] RST_COEF_C = 17'sd1;
	localparam logic [EXTENT_W-1:0] RST_EXTENT = 10'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_A,
		REG_COEF_B,
		REG_COEF_C,
		REG_HALF_EXTENT
	} cfg_reg_t;

endpackage

@@ design/mpr_mac.sv @@
module mpr_mac import mpr_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [VALUE_W-1:0] mul_a,
	input  logic signed [X_W-1:0]     mul_b,
	input  logic signed [VALUE_W-1:0] addend,
	output logic signed [VALUE_W-1:0] result
);

	logic signed [VALUE_W+X_W-1:0] prod;
	logic signed [VALUE_W-1:0]     result_q;

	assign prod = mul_a * mul_b;

	// Sum wraps to the value width.
	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= prod[VALUE_W-1:0] + addend;
		end
	end

	assign result = result_q;

endmodule

@@ design/midpoint_parabola_raster_top.sv @@
// Midpoint parabola rasterizer for y = a*x^2 + b*x + c. An input item with restart set
// loads the coefficient registers and prepares a new curve with an 11-bit shift-subtract
// division for the vertex followed by five passes through the single shared multiply-add
// unit, and then yields a result with point_valid 0 and trace_done 0. A restart with
// coef_a zero yields trace_done 1 and coef_error 1. An advance item yields the next
// left-branch point and its mirror about the vertex; when x steps, the block goes on
// through ST_ADV2 and ST_ADV3 before it takes a new item, as the new decision value
// goes through the multiply-add unit. Once the trace has run past the vertex or below
// the minimum y, advances report trace_done 1. The block takes no new item while it
// works on one or while a result waits and is not being taken.
module midpoint_parabola_raster_top import mpr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,    // [0] restart, rest zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [10:0] point_x, [23:11] mirror_x, [55:24] point_y, [56] trace_done,
	// [57] coef_error, rest zero
	output logic [M_DATA_W-1:0]   m_tdata,
	output logic                  m_tuser,    // [0] point_valid
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_T0,
		ST_Y0,
		ST_T1,
		ST_M1,
		ST_D0,
		ST_FIN,
		ST_ADV2,
		ST_ADV3
	} state_t;

	state_t state_q;

	logic signed [COEF_A_W-1:0] coef_a_q;
	logic signed [COEF_B_W-1:0] coef_b_q;
	logic signed [COEF_C_W-1:0] coef_c_q;
	logic [EXTENT_W-1:0]        half_extent_q;

	logic signed [A_W-1:0]     a_q;
	logic signed [B_W-1:0]     b_q;
	logic signed [C_W-1:0]     c_q;
	logic signed [K_W-1:0]     k_q;
	logic signed [X_W-1:0]     cur_x_q;
	logic signed [X_W-1:0]     vertex_q;
	logic signed [VALUE_W-1:0] cur_y_q;
	logic signed [VALUE_W-1:0] min_y_q;
	logic signed [VALUE_W-1:0] decision_q;
	logic signed [VALUE_W-1:0] sum_q;
	logic                      concave_q;
	logic                      active_q;
	logic                      err_q;

	logic [QUO_W-1:0]     dq_q;
	logic [REM_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic                      m_tvalid_q;
	logic                      pv_q;
	logic [PX_W-1:0]           px_q;
	logic [MX_W-1:0]           mx_q;
	logic [VALUE_W-1:0]        py_q;
	logic                      done_q;
	logic                      oerr_q;

	logic                      accept;
	logic                      restart;
	logic                      out_load;
	logic                      a_zero;
	logic                      a_neg;
	logic signed [A_W-1:0]     a_ext;
	logic signed [A_W-1:0]     a_pos;
	logic signed [B_W-1:0]     b_ext;
	logic signed [B_W-1:0]     b_pos;
	logic signed [B_W-1:0]     b_mag;
	logic signed [C_W-1:0]     c_ext;
	logic signed [C_W-1:0]     c_pos;
	logic                      in_range;
	logic signed [MX_W-1:0]    mirror;
	logic signed [VALUE_W-1:0] y_out;
	logic                      dec_pos;
	logic [REM_W:0]            trial;
	logic [REM_W:0]            divisor;
	logic [REM_W:0]            trial_sub;
	logic                      div_ge;
	logic signed [X_W-1:0]     quot;
	logic signed [X_W-1:0]     vertex_nxt;

	logic                      mac_en;
	logic signed [VALUE_W-1:0] mac_a;
	logic signed [X_W-1:0]     mac_b;
	logic signed [VALUE_W-1:0] mac_s;
	logic signed [VALUE_W-1:0] mac_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q      <= RST_COEF_A;
			coef_b_q      <= RST_COEF_B;
			coef_c_q      <= RST_COEF_C;
			half_extent_q <= RST_EXTENT;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_COEF_A:      coef_a_q      <= cfg_data[COEF_A_W-1:0];
				REG_COEF_B:      coef_b_q      <= cfg_data[COEF_B_W-1:0];
				REG_COEF_C:      coef_c_q      <= cfg_data[COEF_C_W-1:0];
				REG_HALF_EXTENT: half_extent_q <= cfg_data[EXTENT_W-1:0];
				default:         coef_a_q      <= coef_a_q;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign restart  = s_tdata[0];
	// A result is loaded by every advance, by a rejected restart and at the end of setup.
	assign out_load = (state_q == ST_FIN) || (accept && (!restart || a_zero));

	always_comb begin
		// Make the curve open upward: negate all three coefficients when a < 0.
		a_zero = (coef_a_q == '0);
		a_neg  = coef_a_q[COEF_A_W-1];
		a_ext  = A_W'(coef_a_q);
		b_ext  = B_W'(coef_b_q);
		c_ext  = C_W'(coef_c_q);
		a_pos  = a_neg ? -a_ext : a_ext;
		b_pos  = a_neg ? -b_ext : b_ext;
		c_pos  = a_neg ? -c_ext : c_ext;
		b_mag  = b_pos[B_W-1] ? -b_pos : b_pos;

		in_range = (cur_x_q <= vertex_q) && (cur_y_q >= min_y_q);
		mirror   = (MX_W'(vertex_q) <<< 1) - MX_W'(cur_x_q);
		y_out    = concave_q ? -cur_y_q : cur_y_q;
		dec_pos  = (decision_q > 0);

		trial     = {rem_q, dq_q[QUO_W-1]};
		divisor   = {a_q[A_W-2:0], 1'b0};
		div_ge    = (trial >= divisor);
		trial_sub = trial - divisor;

		// Truncation toward zero: the quotient of the magnitudes takes the sign of -b.
		quot       = {1'b0, dq_q};
		vertex_nxt = (b_q > 0) ? -quot : quot;
	end

	always_comb begin
		mac_en = 1'b0;
		mac_a  = VALUE_W'(a_q);
		mac_b  = cur_x_q;
		mac_s  = VALUE_W'(b_q);
		case (state_q)
			ST_T0: begin
				mac_en = 1'b1;
			end
			ST_Y0: begin
				mac_en = 1'b1;
				mac_a  = mac_res;
				mac_s  = VALUE_W'(c_q);
			end
			ST_T1: begin
				mac_en = 1'b1;
				mac_b  = vertex_q;
			end
			ST_M1: begin
				mac_en = 1'b1;
				mac_a  = mac_res;
				mac_b  = vertex_q;
				mac_s  = VALUE_W'(c_q);
			end
			ST_D0: begin
				mac_en = 1'b1;
				mac_a  = VALUE_W'(a_q) <<< 2;
				mac_s  = VALUE_W'(a_q) + (VALUE_W'(b_q) <<< 1) + VALUE_W'(STEP_BIAS);
			end
			ST_ADV2: begin
				mac_en = 1'b1;
				mac_a  = VALUE_W'(a_q) <<< 3;
				mac_b  = cur_x_q + X_W'(1);
				mac_s  = sum_q;
			end
			default: begin
				mac_en = 1'b0;
			end
		endcase
	end

	mpr_mac u_mac (
		.clk    (clk),
		.en     (mac_en),
		.mul_a  (mac_a),
		.mul_b  (mac_b),
		.addend (mac_s),
		.result (mac_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			a_q        <= '0;
			b_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
			cur_x_q    <= '0;
			vertex_q   <= '0;
			cur_y_q    <= '0;
			min_y_q    <= '0;
			decision_q <= '0;
			sum_q      <= '0;
			concave_q  <= 1'b0;
			active_q   <= 1'b0;
			err_q      <= 1'b0;
			dq_q       <= '0;
			rem_q      <= '0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
			pv_q       <= 1'b0;
			px_q       <= '0;
			mx_q       <= '0;
			py_q       <= '0;
			done_q     <= 1'b0;
			oerr_q     <= 1'b0;
		end else begin
			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (accept && restart) begin
						if (a_zero) begin
							err_q      <= 1'b1;
							active_q   <= 1'b0;
							pv_q       <= 1'b0;
							px_q       <= '0;
							mx_q       <= '0;
							py_q       <= '0;
							done_q     <= 1'b1;
							oerr_q     <= 1'b1;
						end else begin
							err_q     <= 1'b0;
							active_q  <= 1'b0;
							concave_q <= a_neg;
							a_q       <= a_pos;
							b_q       <= b_pos;
							c_q       <= c_pos;
							k_q       <= (K_W'(b_pos) <<< 2) + K_W'(STEP_BIAS);
							cur_x_q   <= -X_W'(half_extent_q);
							dq_q      <= b_mag[QUO_W-1:0];
							rem_q     <= '0;
							div_cnt_q <= '0;
							state_q   <= ST_DIV;
						end
					end else if (accept) begin
						oerr_q     <= err_q;
						if (active_q && in_range) begin
							pv_q    <= 1'b1;
							px_q    <= cur_x_q[PX_W-1:0];
							mx_q    <= mirror;
							py_q    <= y_out;
							done_q  <= 1'b0;
							cur_y_q <= cur_y_q - VALUE_W'(1);
							if (dec_pos) begin
								sum_q   <= decision_q + VALUE_W'(k_q);
								state_q <= ST_ADV2;
							end else begin
								decision_q <= decision_q + VALUE_W'(STEP_BIAS);
							end
						end else begin
							active_q <= 1'b0;
							pv_q     <= 1'b0;
							px_q     <= '0;
							mx_q     <= '0;
							py_q     <= '0;
							done_q   <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					rem_q     <= div_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
					dq_q      <= {dq_q[QUO_W-2:0], div_ge};
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_T0;
					end
				end
				ST_T0: begin
					vertex_q <= vertex_nxt;
					state_q  <= ST_Y0;
				end
				ST_Y0: begin
					state_q <= ST_T1;
				end
				ST_T1: begin
					cur_y_q <= mac_res;
					state_q <= ST_M1;
				end
				ST_M1: begin
					state_q <= ST_D0;
				end
				ST_D0: begin
					min_y_q <= mac_res;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					decision_q <= mac_res;
					active_q   <= 1'b1;
					pv_q       <= 1'b0;
					px_q       <= '0;
					mx_q       <= '0;
					py_q       <= '0;
					done_q     <= 1'b0;
					oerr_q     <= err_q;
					state_q    <= ST_IDLE;
				end
				ST_ADV2: begin
					state_q <= ST_ADV3;
				end
				ST_ADV3: begin
					decision_q <= mac_res;
					cur_x_q    <= cur_x_q + X_W'(1);
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = pv_q;
	assign m_tdata  = {6'b0, oerr_q, done_q, py_q, mx_q, px_q};

`ifndef SYNTHESIS
	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> !active_q)
		else $error("coefficient error flag set while a trace is active");

	a_point_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && pv_q |-> !done_q)
		else $error("valid point reported together with trace_done");

	a_restart_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart && !a_zero |=> state_q == ST_DIV && div_cnt_q == '0)
		else $error("restart item did not start the vertex division");
`endif

endmodule
